### rtl/msid_pkg.sv
// shared types, register indexes and constants for the mode select input debouncer
`timescale 1ns / 1ps

package msid_pkg;

  // default countdown width
  localparam int unsigned COUNT_WIDTH = 16;

  // configuration port widths
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 16;
  localparam int unsigned TicksWidth    = 16;
  localparam int unsigned ModeWidth     = 3;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] RegDebounceTicks = 2'd0;
  localparam logic [CfgIndexWidth-1:0] RegTriggerMode   = 2'd1;
  localparam logic [CfgIndexWidth-1:0] RegInvertLevel   = 2'd2;

  // register reset values
  localparam logic [TicksWidth-1:0] DebounceTicksReset = 16'd250;
  localparam logic [ModeWidth-1:0]  TriggerModeReset   = 3'd2;
  localparam logic                  InvertLevelReset   = 1'b0;

  // trigger mode codes, unused codes act as change
  typedef enum logic [ModeWidth-1:0] {
    TRIG_CHANGE  = 3'd0,
    TRIG_RISING  = 3'd1,
    TRIG_FALLING = 3'd2,
    TRIG_LOW     = 3'd3,
    TRIG_HIGH    = 3'd4
  } trig_mode_e;

  // configuration as seen by the core
  typedef struct packed {
    logic [TicksWidth-1:0] debounce_ticks;
    logic [ModeWidth-1:0]  trigger_mode;
    logic                  invert_level;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic event_fired;
    logic accepted_level;
    logic engaged_flag;
    logic phase;
  } result_t;

endpackage

### rtl/msid_core.sv
// debounce state registers and the per-sample update logic
`timescale 1ns / 1ps

module msid_core #(
  parameter int unsigned CountWidth = msid_pkg::COUNT_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  msid_pkg::cfg_t   cfg_i,
  input  logic             step_i,
  input  logic             raw_level_i,
  input  logic             clear_engaged_i,
  output msid_pkg::result_t result_o
);

  logic                  phase_q, phase_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic                  cap_q, cap_d;
  logic                  acc_q, acc_d;
  logic                  eng_q, eng_d;
  logic                  eng_evt;
  logic [CountWidth-1:0] load;
  logic                  lvl;
  logic                  level_mode;
  logic                  mode_match;
  logic                  fired;

  // countdown load value, saturated for a narrow counter
  if (CountWidth >= msid_pkg::TicksWidth) begin : g_load_wide
    assign load = CountWidth'(cfg_i.debounce_ticks);
  end else begin : g_load_sat
    assign load = (|cfg_i.debounce_ticks[msid_pkg::TicksWidth-1:CountWidth]) ?
                  {CountWidth{1'b1}} : cfg_i.debounce_ticks[CountWidth-1:0];
  end

  // working level and mode decode
  assign lvl        = raw_level_i ^ cfg_i.invert_level;
  assign level_mode = (cfg_i.trigger_mode == msid_pkg::TRIG_LOW) ||
                      (cfg_i.trigger_mode == msid_pkg::TRIG_HIGH);

  // trigger test of the captured level against the accepted one
  always_comb begin
    case (cfg_i.trigger_mode)
      msid_pkg::TRIG_RISING:  mode_match = !acc_q && cap_q;
      msid_pkg::TRIG_FALLING: mode_match = acc_q && !cap_q;
      msid_pkg::TRIG_LOW:     mode_match = !cap_q;
      msid_pkg::TRIG_HIGH:    mode_match = cap_q;
      default:                mode_match = cap_q != acc_q;
    endcase
  end

  // next state for one sample
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    cap_d   = cap_q;
    acc_d   = acc_q;
    eng_evt = eng_q;
    fired   = 1'b0;
    if (!phase_q) begin
      if ((lvl != acc_q) || level_mode) begin
        cap_d   = lvl;
        cnt_d   = load;
        phase_d = 1'b1;
      end
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CountWidth'(1);
    end else begin
      if (lvl == cap_q) begin
        if (mode_match) begin
          fired   = 1'b1;
          eng_evt = 1'b1;
        end
        acc_d = cap_q;
      end
      phase_d = 1'b0;
    end
    // clear request acts after the flag is reported
    eng_d = eng_evt && !clear_engaged_i;
  end

  // result reflects the state after this sample
  assign result_o.event_fired    = fired;
  assign result_o.accepted_level = acc_d;
  assign result_o.engaged_flag   = eng_evt;
  assign result_o.phase          = phase_d;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 1'b0;
      cnt_q   <= '0;
      cap_q   <= 1'b0;
      acc_q   <= 1'b0;
      eng_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
      acc_q   <= acc_d;
      eng_q   <= eng_d;
    end
  end

endmodule

### rtl/mode_select_input_debouncer.sv
// top level of the mode select input debouncer with config registers and output skid
`timescale 1ns / 1ps

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------------------
// in       | input     | in_valid_i/in_stall_o  | raw_level_i, clear_engaged_i
// out      | output    | out_valid_o/out_stall_i| event_fired_o, accepted_level_o,
//          |           |                        | engaged_flag_o, phase_o
// cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// one sample is taken per cycle unless stalled; its result is registered in the buffer.
// the state update is a single pass through the core between sample and result register.
// a two-entry output buffer (output register plus skid) lets samples flow while a result
// waits; in_stall_o rises only when both entries are full.
// reset clears the debounce state, the buffer and loads the register defaults.

module mode_select_input_debouncer #(
  parameter int unsigned CountWidth = msid_pkg::COUNT_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               raw_level_i,
  input  logic                               clear_engaged_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               event_fired_o,
  output logic                               accepted_level_o,
  output logic                               engaged_flag_o,
  output logic                               phase_o,
  // configuration channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [msid_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [msid_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  msid_pkg::cfg_t    cfg_q;
  msid_pkg::result_t res;
  msid_pkg::result_t out_q;
  msid_pkg::result_t skid_q;
  logic              out_valid_q;
  logic              skid_valid_q;
  logic              in_acc;
  logic              out_take;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= msid_pkg::DebounceTicksReset;
      cfg_q.trigger_mode   <= msid_pkg::TriggerModeReset;
      cfg_q.invert_level   <= msid_pkg::InvertLevelReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        msid_pkg::RegDebounceTicks: begin
          cfg_q.debounce_ticks <= cfg_data_i[msid_pkg::TicksWidth-1:0];
        end
        msid_pkg::RegTriggerMode: begin
          cfg_q.trigger_mode <= cfg_data_i[msid_pkg::ModeWidth-1:0];
        end
        msid_pkg::RegInvertLevel: begin
          cfg_q.invert_level <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // handshake decode
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;

  // debounce core
  msid_core #(
    .CountWidth(CountWidth)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .step_i         (in_acc),
    .raw_level_i    (raw_level_i),
    .clear_engaged_i(clear_engaged_i),
    .result_o       (res)
  );

  // output register and skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        out_q        <= skid_q;
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_q || out_take) begin
        out_q       <= res;
        out_valid_q <= 1'b1;
      end else begin
        skid_q       <= res;
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign event_fired_o    = out_q.event_fired;
  assign accepted_level_o = out_q.accepted_level;
  assign engaged_flag_o   = out_q.engaged_flag;
  assign phase_o          = out_q.phase;

  // skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // a fired transaction always reports the engaged flag set
  a_event_engaged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.event_fired) |-> out_q.engaged_flag)
    else $error("event reported without engaged flag");

  // an event ends the debounce phase
  a_event_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && res.event_fired) |-> !res.phase)
    else $error("event fired while still debouncing");

endmodule

### test/tb_top.sv
// testbench for the mode select input debouncer: random pin traffic checked against a predictor
`timescale 1ns / 1ps

module tb_top;

  // one pin sample as offered on the input channel
  typedef struct packed {
    logic raw;
    logic clr;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic raw_level_i = 1'b0;
  logic clear_engaged_i = 1'b0;

  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic event_fired_o;
  logic accepted_level_o;
  logic engaged_flag_o;
  logic phase_o;

  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [msid_pkg::CfgIndexWidth-1:0] cfg_index_i = '0;
  logic [msid_pkg::CfgDataWidth-1:0] cfg_data_i = '0;

  // pending samples and expected debounce results
  sample_t pin_samples_q[$];
  msid_pkg::result_t debounce_results_q[$];

  int samples_queued = 0;
  int samples_taken = 0;
  int fail_cnt = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic in_taken = 1'b0;

  // predictor copy of the configuration
  logic [msid_pkg::TicksWidth-1:0] pred_ticks = msid_pkg::DebounceTicksReset;
  logic [msid_pkg::ModeWidth-1:0] pred_mode = msid_pkg::TriggerModeReset;
  logic pred_invert = msid_pkg::InvertLevelReset;

  // predictor copy of the debounce state
  logic deb_busy = 1'b0;
  logic [msid_pkg::TicksWidth-1:0] deb_count = '0;
  logic deb_captured = 1'b0;
  logic deb_accepted = 1'b0;
  logic deb_engaged = 1'b0;

  mode_select_input_debouncer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_level_i      (raw_level_i),
    .clear_engaged_i  (clear_engaged_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .event_fired_o    (event_fired_o),
    .accepted_level_o (accepted_level_o),
    .engaged_flag_o   (engaged_flag_o),
    .phase_o          (phase_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // clock, period 4 ns
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // advance the debounce state by one tick and return the result it reports
  function automatic msid_pkg::result_t debounce_tick(input logic raw, input logic clr);
    logic lvl;
    logic hit;
    msid_pkg::result_t res;
    lvl = raw ^ pred_invert;
    res.event_fired = 1'b0;
    if (!deb_busy) begin
      if (lvl != deb_accepted || pred_mode == msid_pkg::TRIG_LOW ||
          pred_mode == msid_pkg::TRIG_HIGH) begin
        deb_captured = lvl;
        deb_count = pred_ticks;
        deb_busy = 1'b1;
      end
    end else if (deb_count != '0) begin
      deb_count = deb_count - msid_pkg::TicksWidth'(1);
    end else begin
      // level must still match the captured one, else drop back to idle
      if (lvl == deb_captured) begin
        case (pred_mode)
          msid_pkg::TRIG_RISING:  hit = !deb_accepted && deb_captured;
          msid_pkg::TRIG_FALLING: hit = deb_accepted && !deb_captured;
          msid_pkg::TRIG_LOW:     hit = !deb_captured;
          msid_pkg::TRIG_HIGH:    hit = deb_captured;
          default:                hit = deb_captured != deb_accepted;
        endcase
        if (hit) begin
          res.event_fired = 1'b1;
          deb_engaged = 1'b1;
        end
        deb_accepted = deb_captured;
      end
      deb_busy = 1'b0;
    end
    res.accepted_level = deb_accepted;
    res.engaged_flag = deb_engaged;
    res.phase = deb_busy;
    // clear takes effect after the flag is reported
    if (clr) deb_engaged = 1'b0;
    return res;
  endfunction

  // sample driver, one transaction per accepted sample
  always @(negedge clk_i) begin : sample_driver
    sample_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold the stalled transaction
    end else if (pin_samples_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
      nxt = pin_samples_q.pop_front();
      in_valid_i <= 1'b1;
      raw_level_i <= nxt.raw;
      clear_engaged_i <= nxt.clr;
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // result receiver stall, with long hold-offs on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= 40;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // monitor: predict on accepted samples, check accepted results
  always @(posedge clk_i) begin : result_monitor
    msid_pkg::result_t got;
    msid_pkg::result_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        debounce_results_q.push_back(debounce_tick(raw_level_i, clear_engaged_i));
        samples_taken <= samples_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{event_fired_o, accepted_level_o, engaged_flag_o, phase_o};
        if (debounce_results_q.size() == 0) begin
          fail_cnt = fail_cnt + 1;
          $display("%0t: result with nothing expected, actual %b", $time, got);
        end else begin
          want = debounce_results_q.pop_front();
          if (got !== want) begin
            fail_cnt = fail_cnt + 1;
            $display("%0t: mismatch (fired level engaged phase) expected %b actual %b",
                     $time, want, got);
          end
        end
      end
    end
  end

  // queue one sample for the driver
  task automatic push_sample(input logic raw, input logic clr);
    pin_samples_q.push_back('{raw, clr});
    samples_queued = samples_queued + 1;
  endtask

  // wait until every queued sample was taken and every result checked
  task automatic wait_drained();
    @(negedge clk_i);
    while (samples_taken != samples_queued || debounce_results_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // one register write transaction
  task automatic write_reg(input logic [msid_pkg::CfgIndexWidth-1:0] idx,
                           input logic [msid_pkg::CfgDataWidth-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    case (idx)
      msid_pkg::RegDebounceTicks: pred_ticks = val[msid_pkg::TicksWidth-1:0];
      msid_pkg::RegTriggerMode:   pred_mode = val[msid_pkg::ModeWidth-1:0];
      msid_pkg::RegInvertLevel:   pred_invert = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int ticks, input int mode, input int inv);
    write_reg(msid_pkg::RegDebounceTicks, msid_pkg::CfgDataWidth'(ticks));
    write_reg(msid_pkg::RegTriggerMode, msid_pkg::CfgDataWidth'(mode));
    write_reg(msid_pkg::RegInvertLevel, msid_pkg::CfgDataWidth'(inv));
  endtask

  // steady runs around the debounce interval, mixed with single-tick glitches
  task automatic queue_pin_traffic(input int n);
    int left;
    int run;
    int span;
    logic lvl;
    left = n;
    lvl = 1'($urandom_range(0, 1));
    span = (pred_ticks > 40) ? 40 : int'(pred_ticks);
    while (left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        lvl = 1'($urandom_range(0, 1));
        run = 1;
      end else begin
        lvl = ~lvl;
        run = $urandom_range(span + 1, span + 5);
      end
      for (int i = 0; i < run && left > 0; i++) begin
        push_sample(lvl, $urandom_range(0, 3) == 0);
        left = left - 1;
      end
    end
  endtask

  // limit on the run
  initial begin
    #2_000_000;
    $display("mode_select_input_debouncer test failed");
    $finish;
  end

  // stimulus sequence
  initial begin
    int ticks;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero interval, change mode, fire, clear, level lost
    set_config(0, msid_pkg::TRIG_CHANGE, 0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b1, 1'b1);
    push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b1, 1'b0);
    push_sample(1'b0, 1'b0);
    push_sample(1'b0, 1'b1);
    wait_drained();

    // directed: unused mode code acts as change, inverted pin
    set_config(2, 7, 1);
    repeat (5) push_sample(1'b0, 1'b0);
    repeat (5) push_sample(1'b1, 1'b1);
    wait_drained();

    // directed: level modes restart on every idle tick
    set_config(1, msid_pkg::TRIG_LOW, 1);
    repeat (4) push_sample(1'b1, 1'b0);
    wait_drained();
    set_config(1, msid_pkg::TRIG_HIGH, 0);
    repeat (4) push_sample(1'b1, 1'b1);
    wait_drained();

    // random phases over the trigger modes, intervals and polarities
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        tx_idle_pct = 35;
        rx_idle_pct = 58;
      end else if (p < 8) begin
        tx_idle_pct = 58;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      ticks = (p == 1) ? 0 : (p == 6) ? 20 : $urandom_range(0, 6);
      set_config(ticks, (p < 8) ? p : $urandom_range(0, 7), (p / 2) % 2);
      queue_pin_traffic(55);
      if (p == 3 || p == 10) hold_token = hold_token + 1;
      // sender pauses until all results are back mid phase
      if (p == 5) wait_drained();
      queue_pin_traffic(50);
      wait_drained();
    end

    // largest interval last, its countdown outlasts the remaining samples
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    set_config(65535, msid_pkg::TRIG_CHANGE, 0);
    for (int i = 0; i < 40; i++) push_sample(i >= 2, 1'($urandom_range(0, 1)));
    wait_drained();

    repeat (10) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("mode_select_input_debouncer test passed");
    end else begin
      $display("mode_select_input_debouncer test failed");
    end
    $finish;
  end

endmodule
